// File: rtl/fcce_pkg.sv
// shared types, codes and command/status bundles of the cluster chain engine
package fcce_pkg;

    localparam int KIND_W   = 3;
    localparam int BIDX_W   = 13;
    localparam int CLUS_W   = 12;
    localparam int ENTRY_W  = 12;
    localparam int STATUS_W = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic [ENTRY_W-1:0] END_MARK = 12'hfff;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 3'd0,
        KIND_READ   = 3'd1,
        KIND_GET    = 3'd2,
        KIND_SET    = 3'd3,
        KIND_FIND   = 3'd4,
        KIND_APPEND = 3'd5,
        KIND_CLEAR  = 3'd6,
        KIND_NONE   = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DIFFER  = 2'd1,
        ST_WALK    = 2'd2,
        ST_NO_FREE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RA_BIDX = 2'd0,
        RA_LO   = 2'd1,
        RA_HI   = 2'd2
    } raddr_sel_t;

    typedef enum logic [2:0] {
        EC_CLUS = 3'd0,
        EC_VAL  = 3'd1,
        EC_NXT  = 3'd2,
        EC_SCAN = 3'd3,
        EC_CUR  = 3'd4
    } ecl_sel_t;

    typedef enum logic [1:0] {
        WV_VAL  = 2'd0,
        WV_END  = 2'd1,
        WV_ZERO = 2'd2
    } wv_sel_t;

    typedef struct packed {
        logic       accept;
        logic       load_do;
        raddr_sel_t rd_sel;
        logic       wr_lo;
        logic       wr_hi;
        logic       lo_ld;
        logic       hi_ld;
        logic       byte_cap;
        logic       ecl_ld;
        ecl_sel_t   ecl_sel;
        logic       wv_ld;
        wv_sel_t    wv_sel;
        logic       cur_clus;
        logic       cur_nxt;
        logic       nxt_ld;
        logic       steps_clr;
        logic       steps_inc;
        logic       scan_init;
        logic       scan_inc;
        logic       ent_cap;
        logic       ent_scan;
        logic       st_ld;
        status_t    st_val;
        logic       push;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  copies_differ;
        logic  entry_zero;
        logic  nxt_end;
        logic  steps_max;
        logic  scan_end;
        logic  out_busy;
    } sts_t;

endpackage

// File: rtl/fat12_cluster_chain_engine_core.sv
// top level of the fat12 cluster chain engine
// find free scans clusters upward from 2; append and clear walk the chain link by link
// all table work goes through one byte memory with one read and one write port
// throughput: one request at a time; a new request is taken while a result waits
// reset clears control and sets the search limit to 2849; table contents stay undefined
module fat12_cluster_chain_engine_core
    import fcce_pkg::*;
#(
    parameter int SECTOR_BYTES  = 512,
    parameter int TABLE_SECTORS = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // request: tuser = kind[2:0]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [KIND_W-1:0]      s_tuser,
    // byte_index[12:0], first_copy_byte[20:13], second_copy_byte[28:21],
    // cluster[40:29], entry_value[52:41], zero pad [55:53]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result: byte_out[7:0], entry_out[19:8], status[21:20], zero pad [23:22]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // free search limit write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CLUS_W-1:0]      cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // limit register always takes a write
    assign cfg_ready = 1'b1;

    // sequencer: walks, searches and byte sub-steps
    fcce_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // memory, entry packing and the result register
    fcce_datapath #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .TABLE_SECTORS(TABLE_SECTORS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_kind  (s_tuser),
        .in_data  (s_tdata),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .out_data (m_tdata)
    );

endmodule

// File: rtl/fcce_ram.sv
// generic single write port ram with registered read
module fcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4608
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/fcce_datapath.sv
// table memory, entry packing, walk registers and result buffering
module fcce_datapath
    import fcce_pkg::*;
#(
    parameter int SECTOR_BYTES  = 512,
    parameter int TABLE_SECTORS = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic [KIND_W-1:0]      in_kind,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  logic                   cfg_we,
    input  logic [CLUS_W-1:0]      cfg_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [OUT_TDATA_W-1:0] out_data
);

    localparam int TABLE_BYTES = SECTOR_BYTES * TABLE_SECTORS;
    localparam int AW          = $clog2(TABLE_BYTES);
    localparam int ENTRY_COUNT = (TABLE_BYTES / 3) * 2;
    localparam int SW          = $clog2(ENTRY_COUNT + 1);

    logic [KIND_W-1:0]  kind_reg;
    logic [BIDX_W-1:0]  bidx_reg;
    logic [7:0]         b1_reg, b2_reg;
    logic [CLUS_W-1:0]  clus_reg, val_reg;
    logic [CLUS_W-1:0]  ecl_reg, cur_reg, scan_reg;
    logic [ENTRY_W-1:0] nxt_reg, wv_reg;
    logic [7:0]         lo_reg, hi_reg;
    logic [SW-1:0]      steps_reg;
    logic [CLUS_W-1:0]  limit_reg;
    logic [7:0]         res_byte_reg;
    logic [ENTRY_W-1:0] res_entry_reg;
    logic [STATUS_W-1:0] res_st_reg;
    logic               out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [7:0]  rdata, wdata;
    logic [AW-1:0] raddr, waddr;
    logic        we;
    logic [31:0] base32, lo32, hi32;
    logic        odd, ecl_ok, bidx_ok;
    logic [ENTRY_W-1:0] raw_entry, entry;
    logic [7:0]  wlo, whi;
    logic [31:0] lim32;

    assign odd     = ecl_reg[0];
    assign ecl_ok  = (32'(ecl_reg) < 32'(ENTRY_COUNT));
    assign bidx_ok = (32'(bidx_reg) < 32'(TABLE_BYTES));
    assign base32  = 32'(ecl_reg[CLUS_W-1:1]) * 32'd3;
    assign lo32    = base32 + 32'(odd);
    assign hi32    = lo32 + 32'd1;

    // even entry: low byte plus low nibble of middle; odd: high nibble of middle plus high byte
    assign raw_entry = odd ? {hi_reg, lo_reg[7:4]} : {hi_reg[3:0], lo_reg};
    assign entry     = ecl_ok ? raw_entry : '0;
    assign wlo       = odd ? {wv_reg[3:0], lo_reg[3:0]} : wv_reg[7:0];
    assign whi       = odd ? wv_reg[11:4] : {hi_reg[7:4], wv_reg[11:8]};

    always_comb
    begin
        unique case (cmd.rd_sel)
            RA_BIDX: raddr = AW'(bidx_reg);
            RA_LO:   raddr = lo32[AW-1:0];
            RA_HI:   raddr = hi32[AW-1:0];
            default: raddr = AW'(bidx_reg);
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(bidx_reg);
        wdata = b1_reg;
        priority if (cmd.load_do)
        begin
            we = (b1_reg == b2_reg) && bidx_ok;
        end
        else if (cmd.wr_lo)
        begin
            we    = ecl_ok;
            waddr = lo32[AW-1:0];
            wdata = wlo;
        end
        else if (cmd.wr_hi)
        begin
            we    = ecl_ok;
            waddr = hi32[AW-1:0];
            wdata = whi;
        end
        else
        begin
            we = 1'b0;
        end
    end

    fcce_ram #(
        .WIDTH(8),
        .DEPTH(TABLE_BYTES)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign lim32 = (32'(limit_reg) > 32'(ENTRY_COUNT)) ? 32'(ENTRY_COUNT) : 32'(limit_reg);

    assign sts.kind          = kind_t'(kind_reg);
    assign sts.copies_differ = (b1_reg != b2_reg);
    assign sts.entry_zero    = (entry == '0);
    assign sts.nxt_end       = (nxt_reg == END_MARK);
    assign sts.steps_max     = (32'(steps_reg) == 32'(ENTRY_COUNT));
    assign sts.scan_end      = (32'(scan_reg) >= lim32);
    assign sts.out_busy      = out_valid_reg && !out_ready;

    // payload, walk and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= in_kind;
            bidx_reg <= in_data[12:0];
            b1_reg   <= in_data[20:13];
            b2_reg   <= in_data[28:21];
            clus_reg <= in_data[40:29];
            val_reg  <= in_data[52:41];
        end
        if (cmd.lo_ld)
        begin
            lo_reg <= rdata;
        end
        if (cmd.hi_ld)
        begin
            hi_reg <= rdata;
        end
        if (cmd.ecl_ld)
        begin
            unique case (cmd.ecl_sel)
                EC_CLUS: ecl_reg <= clus_reg;
                EC_VAL:  ecl_reg <= val_reg;
                EC_NXT:  ecl_reg <= nxt_reg;
                EC_SCAN: ecl_reg <= scan_reg;
                EC_CUR:  ecl_reg <= cur_reg;
                default: ecl_reg <= clus_reg;
            endcase
        end
        if (cmd.wv_ld)
        begin
            unique case (cmd.wv_sel)
                WV_VAL:  wv_reg <= val_reg;
                WV_END:  wv_reg <= END_MARK;
                WV_ZERO: wv_reg <= '0;
                default: wv_reg <= '0;
            endcase
        end
        if (cmd.cur_clus)
        begin
            cur_reg <= clus_reg;
        end
        else if (cmd.cur_nxt)
        begin
            cur_reg <= nxt_reg;
        end
        if (cmd.nxt_ld)
        begin
            nxt_reg <= entry;
        end
        if (cmd.steps_clr)
        begin
            steps_reg <= '0;
        end
        else if (cmd.steps_inc)
        begin
            steps_reg <= steps_reg + SW'(1);
        end
        if (cmd.scan_init)
        begin
            scan_reg <= CLUS_W'(2);
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + CLUS_W'(1);
        end
        if (cmd.accept)
        begin
            res_byte_reg  <= '0;
            res_entry_reg <= '0;
            res_st_reg    <= ST_OK;
        end
        else
        begin
            if (cmd.byte_cap && bidx_ok)
            begin
                res_byte_reg <= rdata;
            end
            if (cmd.ent_cap)
            begin
                res_entry_reg <= cmd.ent_scan ? scan_reg : entry;
            end
            if (cmd.st_ld)
            begin
                res_st_reg <= cmd.st_val;
            end
        end
        if (cmd.push)
        begin
            out_data_reg <= {2'b00, res_st_reg, res_entry_reg, res_byte_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= CLUS_W'(2849);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/fcce_ctrl.sv
// operation sequencer of the cluster chain engine
module fcce_ctrl
    import fcce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RB_CAP,
        S_ER_LO, S_ER_HI, S_ER_CAP, S_EW_LO, S_EW_HI,
        S_GET, S_SET, S_FF_CHK, S_FF_TEST,
        S_AP_FIRST, S_AP_LOOP, S_AP_NEXT, S_AP_W2, S_AP_W3, S_AP_W4,
        S_CL_FIRST, S_CL_LOOP, S_CL_ADV, S_DONE
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.kind)
                    KIND_LOAD:
                    begin
                        cmd.load_do = 1'b1;
                        cmd.st_ld   = 1'b1;
                        cmd.st_val  = sts.copies_differ ? ST_DIFFER : ST_OK;
                        state_next  = S_DONE;
                    end
                    KIND_READ:
                    begin
                        cmd.rd_sel = RA_BIDX;
                        state_next = S_RB_CAP;
                    end
                    KIND_GET:
                    begin
                        cmd.ecl_ld = 1'b1;
                        ret_next   = S_GET;
                        state_next = S_ER_LO;
                    end
                    KIND_SET:
                    begin
                        cmd.ecl_ld = 1'b1;
                        cmd.wv_ld  = 1'b1;
                        cmd.wv_sel = WV_VAL;
                        ret_next   = S_SET;
                        state_next = S_ER_LO;
                    end
                    KIND_FIND:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_FF_CHK;
                    end
                    KIND_APPEND:
                    begin
                        cmd.ecl_ld    = 1'b1;
                        cmd.cur_clus  = 1'b1;
                        cmd.steps_clr = 1'b1;
                        ret_next      = S_AP_FIRST;
                        state_next    = S_ER_LO;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.ecl_ld    = 1'b1;
                        cmd.cur_clus  = 1'b1;
                        cmd.steps_clr = 1'b1;
                        ret_next      = S_CL_FIRST;
                        state_next    = S_ER_LO;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RB_CAP:
            begin
                cmd.byte_cap = 1'b1;
                state_next   = S_DONE;
            end
            S_ER_LO:
            begin
                cmd.rd_sel = RA_LO;
                state_next = S_ER_HI;
            end
            S_ER_HI:
            begin
                cmd.rd_sel = RA_HI;
                cmd.lo_ld  = 1'b1;
                state_next = S_ER_CAP;
            end
            S_ER_CAP:
            begin
                cmd.hi_ld  = 1'b1;
                state_next = ret_reg;
            end
            S_EW_LO:
            begin
                cmd.wr_lo  = 1'b1;
                state_next = S_EW_HI;
            end
            S_EW_HI:
            begin
                cmd.wr_hi  = 1'b1;
                state_next = ret_reg;
            end
            S_GET:
            begin
                cmd.ent_cap = 1'b1;
                state_next  = S_DONE;
            end
            S_SET:
            begin
                ret_next   = S_DONE;
                state_next = S_EW_LO;
            end
            S_FF_CHK:
            begin
                if (sts.scan_end)
                begin
                    cmd.st_ld  = 1'b1;
                    cmd.st_val = ST_NO_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.ecl_ld  = 1'b1;
                    cmd.ecl_sel = EC_SCAN;
                    ret_next    = S_FF_TEST;
                    state_next  = S_ER_LO;
                end
            end
            S_FF_TEST:
            begin
                if (sts.entry_zero)
                begin
                    cmd.ent_cap  = 1'b1;
                    cmd.ent_scan = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_FF_CHK;
                end
            end
            S_AP_FIRST:
            begin
                if (sts.entry_zero)
                begin
                    cmd.wv_ld  = 1'b1;
                    cmd.wv_sel = WV_END;
                    ret_next   = S_DONE;
                    state_next = S_EW_LO;
                end
                else
                begin
                    cmd.nxt_ld = 1'b1;
                    state_next = S_AP_LOOP;
                end
            end
            S_AP_LOOP:
            begin
                priority if (sts.nxt_end)
                begin
                    cmd.ecl_ld  = 1'b1;
                    cmd.ecl_sel = EC_VAL;
                    cmd.wv_ld   = 1'b1;
                    cmd.wv_sel  = WV_END;
                    ret_next    = S_AP_W2;
                    state_next  = S_ER_LO;
                end
                else if (sts.steps_max)
                begin
                    cmd.st_ld  = 1'b1;
                    cmd.st_val = ST_WALK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.cur_nxt   = 1'b1;
                    cmd.ecl_ld    = 1'b1;
                    cmd.ecl_sel   = EC_NXT;
                    cmd.steps_inc = 1'b1;
                    ret_next      = S_AP_NEXT;
                    state_next    = S_ER_LO;
                end
            end
            S_AP_NEXT:
            begin
                cmd.nxt_ld = 1'b1;
                state_next = S_AP_LOOP;
            end
            S_AP_W2:
            begin
                ret_next   = S_AP_W3;
                state_next = S_EW_LO;
            end
            S_AP_W3:
            begin
                // tail entry is re-read: it may share a byte with the new cluster
                cmd.cur_nxt = 1'b0;
                cmd.ecl_ld  = 1'b1;
                cmd.ecl_sel = EC_CUR;
                cmd.wv_ld   = 1'b1;
                cmd.wv_sel  = WV_VAL;
                ret_next    = S_AP_W4;
                state_next  = S_ER_LO;
            end
            S_AP_W4:
            begin
                ret_next   = S_DONE;
                state_next = S_EW_LO;
            end
            S_CL_FIRST:
            begin
                cmd.nxt_ld = 1'b1;
                state_next = S_CL_LOOP;
            end
            S_CL_LOOP:
            begin
                priority if (sts.nxt_end)
                begin
                    cmd.wv_ld  = 1'b1;
                    cmd.wv_sel = WV_ZERO;
                    ret_next   = S_DONE;
                    state_next = S_EW_LO;
                end
                else if (sts.steps_max)
                begin
                    cmd.st_ld  = 1'b1;
                    cmd.st_val = ST_WALK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.wv_ld  = 1'b1;
                    cmd.wv_sel = WV_ZERO;
                    ret_next   = S_CL_ADV;
                    state_next = S_EW_LO;
                end
            end
            S_CL_ADV:
            begin
                cmd.cur_nxt   = 1'b1;
                cmd.ecl_ld    = 1'b1;
                cmd.ecl_sel   = EC_NXT;
                cmd.steps_inc = 1'b1;
                ret_next      = S_CL_FIRST;
                state_next    = S_ER_LO;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_DONE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule
